// ----- src/group_bit_width_packer_defines.svh -----
// Assertion macros used by the group bit width packer RTL.
`ifndef GROUP_BIT_WIDTH_PACKER_DEFINES_SVH
`define GROUP_BIT_WIDTH_PACKER_DEFINES_SVH

// Same-cycle implication, checked on clk, quiet while arst_n is low.
`define GBWP_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk, quiet while arst_n is low.
`define GBWP_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/gbwp_pkg.sv -----
// Types and constants shared by the group bit width packer modules.
`default_nettype none

package gbwp_pkg;

	localparam int unsigned NumSymbols   = 8;
	localparam int unsigned SymbolWidth  = 8;
	localparam int unsigned GroupWidth   = NumSymbols * SymbolWidth;
	localparam int unsigned ModeWidth    = 3;
	localparam int unsigned BytesWidth   = 4;
	localparam int unsigned CtrlWidth    = NumSymbols * ModeWidth;
	localparam int unsigned AccWidth     = CtrlWidth - ModeWidth;
	localparam int unsigned SlotWidth    = 3;
	localparam int unsigned OutTotWidth  = 32;

	localparam logic [ModeWidth-1:0] ModeZero = 3'd0;
	localparam logic [SlotWidth-1:0] SlotLast = 3'd7;

	// Per-group packing result.
	typedef struct packed {
		logic [ModeWidth-1:0]  mode;
		logic [GroupWidth-1:0] payload;
		logic [BytesWidth-1:0] nbytes;
	} pack_res_t;

	// Control word and byte total for one group.
	typedef struct packed {
		logic [CtrlWidth-1:0]   ctrl;
		logic                   ctrl_valid;
		logic [OutTotWidth-1:0] total;
	} acc_res_t;

endpackage

`default_nettype wire

// ----- src/group_bit_width_packer.sv -----
// Top level of the group bit width packer: input stage, packing, result stage.
//
// Usage: each input word on the s_ channel is one group of eight signed bytes
// (byte i at s_tdata bits 8i+7..8i); s_tlast marks the final group of a plane.
// Every group gives exactly one result word on the m_ channel holding the
// group mode, the packed payload, its byte count, the control word and the
// running byte total. m_tuser is high when the control word is complete or
// flushed; m_tlast repeats s_tlast and then the total is the plane size.
// Each result word shows on m_ once its group has left the input register
// for the result register. With m_tready high, throughput is one group per
// cycle: the only state carried between groups is the mode accumulator, the
// slot count and the byte counter, all updated as the group enters the
// result register. When the receiver holds m_tready low the result
// register keeps its word and the input register fills, after which
// s_tready drops; nothing is dropped or repeated. Reset empties both stages
// and clears the control set and the byte total. A last group flushes a
// partial control word with zeros in the unused slots and restarts the total.
`default_nettype none

module group_bit_width_packer #(
	parameter int unsigned TOTAL_WIDTH = 32
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [63:0]  s_tdata,   // [63:0] group_symbols
	input  wire logic         s_tlast,   // last_group
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [127:0]      m_tdata,   // [2:0] group_mode, [66:3] payload,
	                                     // [70:67] payload_bytes, [94:71] control_word,
	                                     // [126:95] total_bytes, [127] zero
	output logic              m_tuser,   // control_valid
	output logic              m_tlast    // total_valid
);
	import gbwp_pkg::*;

	// Input stage.
	logic                  valid_s1;
	logic [GroupWidth-1:0] grp_s1;
	logic                  last_s1;

	// Result stage.
	logic                   valid_s2;
	logic [ModeWidth-1:0]   mode_s2;
	logic [GroupWidth-1:0]  payload_s2;
	logic [BytesWidth-1:0]  nbytes_s2;
	logic [CtrlWidth-1:0]   ctrl_s2;
	logic                   ctrl_valid_s2;
	logic [OutTotWidth-1:0] total_s2;
	logic                   last_s2;

	logic      out_free;
	logic      advance;
	pack_res_t pack_res;
	acc_res_t  acc_res;

	// The result register frees up when empty or when its word is taken;
	// the input register can then move forward and take a new word.
	assign out_free = !valid_s2 || m_tready;
	assign advance  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			grp_s1  <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	gbwp_width_pack u_width_pack (
		.grp (grp_s1),
		.res (pack_res)
	);

	// The accumulators advance exactly once per group, as it enters the
	// result register, so group order is kept across stalls.
	gbwp_accum #(
		.TOTAL_WIDTH (TOTAL_WIDTH)
	) u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (advance),
		.last   (last_s1),
		.mode   (pack_res.mode),
		.nbytes (pack_res.nbytes),
		.res    (acc_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			mode_s2       <= pack_res.mode;
			payload_s2    <= pack_res.payload;
			nbytes_s2     <= pack_res.nbytes;
			ctrl_s2       <= acc_res.ctrl;
			ctrl_valid_s2 <= acc_res.ctrl_valid;
			total_s2      <= acc_res.total;
			last_s2       <= last_s1;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {1'b0, total_s2, ctrl_s2, nbytes_s2, payload_s2, mode_s2};
	assign m_tuser  = ctrl_valid_s2;
	assign m_tlast  = last_s2;

endmodule

`default_nettype wire

// ----- src/gbwp_width_pack.sv -----
// Combinational width selection and field packing for one group of eight bytes.
`default_nettype none

module gbwp_width_pack (
	input  wire logic [gbwp_pkg::GroupWidth-1:0] grp,
	output gbwp_pkg::pack_res_t                  res
);
	import gbwp_pkg::*;

	logic [SymbolWidth-2:0] mag_or;
	logic [ModeWidth-1:0]   top_bit;
	logic [GroupWidth-1:0]  cand [2:8];

	// Fold each byte onto its magnitude and OR them; bit 0 is forced so a
	// nonzero group always gets at least two-bit fields.
	always_comb begin
		mag_or = 7'd1;
		for (int i = 0; i < NumSymbols; i++) begin
			mag_or = mag_or | (grp[8*i+7] ? ~grp[8*i +: 7] : grp[8*i +: 7]);
		end
	end

	always_comb begin
		top_bit = 3'd0;
		for (int k = 0; k < SymbolWidth - 1; k++) begin
			if (mag_or[k]) begin
				top_bit = 3'(k);
			end
		end
	end

	// One packing candidate per field width, each with fixed slices.
	for (genvar w = 2; w <= 8; w++) begin : g_width
		always_comb begin
			logic [SymbolWidth-1:0] biased;
			cand[w] = '0;
			for (int i = 0; i < NumSymbols; i++) begin
				biased = grp[8*i +: 8] + 8'(1 << (w - 1));
				cand[w][i*w +: w] = biased[w-1:0];
			end
		end
	end

	always_comb begin
		if (grp == '0) begin
			res.mode    = ModeZero;
			res.payload = '0;
			res.nbytes  = '0;
		end else begin
			res.mode    = top_bit + 3'd1;
			res.payload = cand[top_bit + 4'd2];
			res.nbytes  = {1'b0, top_bit} + 4'd2;
		end
	end

endmodule

`default_nettype wire

// ----- src/gbwp_accum.sv -----
// Control word gathering and running byte total, updated once per group.
`default_nettype none
`include "group_bit_width_packer_defines.svh"

module gbwp_accum #(
	parameter int unsigned TOTAL_WIDTH = 32
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             upd,
	input  wire logic                             last,
	input  wire logic [gbwp_pkg::ModeWidth-1:0]   mode,
	input  wire logic [gbwp_pkg::BytesWidth-1:0]  nbytes,
	output gbwp_pkg::acc_res_t                    res
);
	import gbwp_pkg::*;

	logic [AccWidth-1:0]    acc_q;
	logic [SlotWidth-1:0]   slot_q;
	logic [TOTAL_WIDTH-1:0] total_q;

	logic [CtrlWidth-1:0]   acc_full;
	logic                   flush;
	logic [TOTAL_WIDTH-1:0] total_sum;
	logic [63:0]            total_ext;

	assign acc_full  = {3'b000, acc_q} | (CtrlWidth'(mode) << (5'(slot_q) * 5'd3));
	assign flush     = (slot_q == SlotLast) || last;
	assign total_sum = total_q + TOTAL_WIDTH'(nbytes);
	assign total_ext = 64'(total_sum);

	assign res.ctrl       = flush ? acc_full : '0;
	assign res.ctrl_valid = flush;
	assign res.total      = total_ext[OutTotWidth-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			slot_q  <= '0;
			total_q <= '0;
		end else if (upd) begin
			if (flush) begin
				acc_q  <= '0;
				slot_q <= '0;
			end else begin
				acc_q  <= acc_full[AccWidth-1:0];
				slot_q <= slot_q + 3'd1;
			end
			total_q <= last ? '0 : total_sum;
		end
	end

	`GBWP_ASSERT_NXT(a_flush_clears, upd && flush, slot_q == '0 && acc_q == '0, "set not cleared after flush")
	`GBWP_ASSERT_NXT(a_slot_steps, upd && !flush, slot_q == $past(slot_q) + 3'd1, "slot did not advance")
	`GBWP_ASSERT_NXT(a_total_restart, upd && last, total_q == '0, "byte total not restarted")

endmodule

`default_nettype wire

// ----- tb/group_bit_width_packer_test.sv -----
// Self-checking testbench for the group bit width packer stream block.
`default_nettype none

module group_bit_width_packer_test;
	import gbwp_pkg::*;

	// Cycles without any accepted word, while work is pending, before the run is abandoned.
	localparam int unsigned StallLimit = 4000;
	// Cycles allowed after the last result for a stray word to show up.
	localparam int unsigned TailCycles = 8;
	localparam int unsigned RandomPerPhase = 282;

	typedef struct {
		logic [GroupWidth-1:0] symbols;
		logic                  last;
	} group_item_t;

	typedef struct {
		logic [ModeWidth-1:0]   mode;
		logic [GroupWidth-1:0]  payload;
		logic [BytesWidth-1:0]  nbytes;
		logic [CtrlWidth-1:0]   ctrl;
		logic                   ctrl_valid;
		logic [OutTotWidth-1:0] total;
		logic                   total_valid;
	} pack_result_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [63:0]  s_tdata = '0;   // [63:0] group_symbols
	logic         s_tlast = 1'b0; // last_group
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [127:0] m_tdata;        // [2:0] group_mode, [66:3] payload, [70:67] payload_bytes,
	                              // [94:71] control_word, [126:95] total_bytes, [127] zero
	logic         m_tuser;        // control_valid
	logic         m_tlast;        // total_valid

	group_item_t  groups_to_send[$];
	pack_result_t results_due[$];

	// Predictor state: modes of the current set, position in the set, plane byte count.
	logic [AccWidth-1:0]    set_modes = '0;
	logic [SlotWidth-1:0]   set_pos = '0;
	logic [OutTotWidth-1:0] plane_bytes = '0;

	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned stall_cycles = 0;
	int unsigned errors = 0;

	group_bit_width_packer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Works out the result word of one accepted group and advances the predictor state.
	task automatic pack_group(input logic [GroupWidth-1:0] grp, input logic last);
		pack_result_t res;
		logic [7:0] sym;
		logic [7:0] orv;
		logic [7:0] field;
		logic [15:0] mask;
		int unsigned top;
		int unsigned width_b;
		logic [CtrlWidth-1:0] modes;
		res = '{default: '0};
		if (grp != '0) begin
			// Folding each byte with its sign leaves the magnitude; the top set bit
			// of their OR picks the narrowest field that holds every byte.
			orv = 8'd1;
			for (int i = 0; i < NumSymbols; i++) begin
				sym = grp[8*i +: 8];
				orv = orv | (sym[7] ? ~sym : sym);
			end
			top = 0;
			for (int k = 0; k < 8; k++)
				if (orv[k])
					top = k;
			width_b = top + 2;
			res.mode = ModeWidth'(top + 1);
			res.nbytes = BytesWidth'(width_b);
			mask = (16'd1 << width_b) - 16'd1;
			for (int i = 0; i < NumSymbols; i++) begin
				sym = grp[8*i +: 8] + (8'd1 << (width_b - 1));
				field = sym & mask[7:0];
				res.payload = res.payload | (GroupWidth'(field) << (width_b * i));
			end
		end
		modes = {{ModeWidth{1'b0}}, set_modes} | (CtrlWidth'(res.mode) << (ModeWidth * set_pos));
		if (set_pos == SlotLast || last) begin
			res.ctrl = modes;
			res.ctrl_valid = 1'b1;
			set_modes = '0;
			set_pos = '0;
		end else begin
			set_modes = modes[AccWidth-1:0];
			set_pos = set_pos + 1'b1;
		end
		plane_bytes = plane_bytes + OutTotWidth'(res.nbytes);
		res.total = plane_bytes;
		res.total_valid = last;
		if (last)
			plane_bytes = '0;
		results_due.push_back(res);
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			errors++;
		end
	endtask

	task automatic add_group(input logic [GroupWidth-1:0] symbols, input logic last);
		group_item_t item;
		item.symbols = symbols;
		item.last = last;
		groups_to_send.push_back(item);
	endtask

	// Random group: mostly bytes confined to one magnitude width, some zero groups,
	// some fully random. Plane ends land at random slots of the control set.
	task automatic add_random_group();
		logic [GroupWidth-1:0] grp;
		logic [7:0] raw;
		logic [7:0] keep;
		int unsigned kind;
		int unsigned k;
		kind = $urandom_range(99);
		grp = '0;
		if (kind < 8) begin
			grp = '0;
		end else if (kind < 20) begin
			grp = {$urandom, $urandom};
		end else begin
			k = $urandom_range(7);
			keep = (k == 7) ? 8'hff : ((8'd1 << (k + 1)) - 8'd1);
			for (int i = 0; i < NumSymbols; i++) begin
				raw = 8'($urandom) & keep;
				// Sign-extend from the chosen width.
				if (k < 7 && raw[k])
					raw = raw | ~keep;
				grp[8*i +: 8] = raw;
			end
		end
		add_group(grp, $urandom_range(23) == 0);
	endtask

	// Sender: a word stays on the bus until it is taken; the prediction is made
	// at the edge where it is accepted.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				pack_group(s_tdata, s_tlast);
			if (!s_tvalid || s_tready) begin
				if (groups_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tdata <= groups_to_send[0].symbols;
					s_tlast <= groups_to_send[0].last;
					void'(groups_to_send.pop_front());
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n)
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Receiver side: every accepted result word is checked against the oldest prediction.
	always @(posedge clk) begin
		pack_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (results_due.size() == 0) begin
				$display("%0t: unexpected result word, expected none, actual %0h", $time,
					m_tdata);
				errors++;
			end else begin
				want = results_due.pop_front();
				check_field("group_mode", 64'(want.mode), 64'(m_tdata[2:0]));
				check_field("payload", want.payload, m_tdata[66:3]);
				check_field("payload_bytes", 64'(want.nbytes), 64'(m_tdata[70:67]));
				check_field("control_word", 64'(want.ctrl), 64'(m_tdata[94:71]));
				check_field("total_bytes", 64'(want.total), 64'(m_tdata[126:95]));
				check_field("pad bit", 64'(0), 64'(m_tdata[127]));
				check_field("control_valid", 64'(want.ctrl_valid), 64'(m_tuser));
				check_field("total_valid", 64'(want.total_valid), 64'(m_tlast));
			end
		end
	end

	// Watchdog: only counts while something is still owed in either direction.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(groups_to_send.size() == 0 && !s_tvalid && results_due.size() == 0))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= StallLimit) begin
			$display("%0t: no word accepted for %0d cycles", $time, stall_cycles);
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		for (int phase = 0; phase < 4; phase++) begin
			@(negedge clk);
			case (phase)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 87;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 87;
				end
				default: begin
					send_idle_pct = 32;
					recv_stall_pct = 32;
				end
			endcase
			if (phase == 0) begin
				// One full set: the zero group, the widest and narrowest sign cases, widths 3 to 5.
				add_group(64'h0000000000000000, 1'b0);
				add_group(64'h7f7f7f7f7f7f7f7f, 1'b0);
				add_group(64'h8080808080808080, 1'b0);
				add_group(64'hffffffffffffffff, 1'b0);
				add_group(64'h0101010101010101, 1'b0);
				add_group(64'h0202020202020202, 1'b0);
				add_group(64'h0404040404040404, 1'b0);
				add_group(64'h0808080808080808, 1'b0);
				// Partial set closed by a plane end.
				add_group(64'h1010101010101010, 1'b0);
				add_group(64'h2020202020202020, 1'b0);
				add_group(64'h4040404040404040, 1'b0);
				add_group(64'h00c0000000000000, 1'b1);
				// A plane of one group, then an all-zero plane of one group.
				add_group(64'h0000000000000001, 1'b1);
				add_group(64'h0000000000000000, 1'b1);
				// Plane end landing on the eighth slot of a set.
				add_group(64'h7f00ff0180fe0201, 1'b0);
				add_group(64'h0123456789abcdef, 1'b0);
				add_group(64'hfedcba9876543210, 1'b0);
				add_group(64'h00000000000000ff, 1'b0);
				add_group(64'hff00000000000000, 1'b0);
				add_group(64'h0000000000000080, 1'b0);
				add_group(64'h8000000000000000, 1'b0);
				add_group(64'h0000000000000000, 1'b1);
			end
			for (int n = 0; n < RandomPerPhase; n++)
				add_random_group();
			while (groups_to_send.size() > 0 || s_tvalid || results_due.size() > 0)
				@(negedge clk);
		end
		repeat (TailCycles) @(posedge clk);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

`default_nettype wire

// ----- group_bit_width_packer.f -----
+incdir+src
src/gbwp_pkg.sv
src/gbwp_width_pack.sv
src/gbwp_accum.sv
src/group_bit_width_packer.sv
tb/group_bit_width_packer_test.sv
